// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_CLK_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_CLK_RST(label, clk, prop, msg)
`endif
`endif

// ===== rtl/core/iaf_pkg.sv =====
// Package: opcodes, widths and the per-cell item record of the folding ALU.
`default_nettype none
package iaf_pkg;
  localparam int unsigned DataW = 64;
  localparam int unsigned OpW = 4;

  localparam logic [OpW-1:0] OP_ADD  = 4'd0;
  localparam logic [OpW-1:0] OP_SUB  = 4'd1;
  localparam logic [OpW-1:0] OP_MUL  = 4'd2;
  localparam logic [OpW-1:0] OP_DIVU = 4'd3;
  localparam logic [OpW-1:0] OP_REMU = 4'd4;
  localparam logic [OpW-1:0] OP_AND  = 4'd5;
  localparam logic [OpW-1:0] OP_OR   = 4'd6;
  localparam logic [OpW-1:0] OP_XOR  = 4'd7;
  localparam logic [OpW-1:0] OP_SHL  = 4'd8;
  localparam logic [OpW-1:0] OP_SHRU = 4'd9;
  localparam logic [OpW-1:0] OP_SHRS = 4'd10;
  localparam logic [OpW-1:0] OP_EQ   = 4'd11;
  localparam logic [OpW-1:0] OP_NE   = 4'd12;
  localparam logic [OpW-1:0] OP_LTU  = 4'd13;
  localparam logic [OpW-1:0] OP_LTS  = 4'd14;

  // One item as it travels down the cell row.
  typedef struct packed {
    logic             vld;
    logic [OpW-1:0]   op;
    logic [DataW-1:0] a;       // dividend / left operand
    logic [DataW-1:0] b;       // divisor / right operand
    logic [DataW-1:0] q;       // quotient bits being built, or finished value
    logic [DataW:0]   rem;     // partial remainder
    logic [DataW-1:0] mac;     // multiply accumulator
    logic             ok;
    logic             done;    // value already final in q
  } item_t;
endpackage
`default_nettype wire

// ===== rtl/core/integer_alu_fold_top.sv =====
// Top level of the 64-bit constant-folding ALU.
// Fully pipelined chain: a combinational front cell feeding the first
// register, then 64 row cells each registered, each resolving one quotient
// bit (and, in the first four, one 16-bit multiply slice). One item is
// accepted every cycle while no result waits under out_stall; out_valid
// comes after the first register and the 64 registered row cells. A stall
// on the output freezes the whole chain, which holds its items in place;
// in_stall is high only while a result waits under out_stall.
`default_nettype none
`include "assert_macros.svh"
module integer_alu_fold_top (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [iaf_pkg::OpW-1:0]    in_op,
  input  wire logic [iaf_pkg::DataW-1:0]  in_left_operand,
  input  wire logic [iaf_pkg::DataW-1:0]  in_right_operand,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [iaf_pkg::DataW-1:0]       out_result_value,
  output logic                            out_folded
);
  localparam int unsigned N = iaf_pkg::DataW;
  iaf_pkg::item_t front_item;
  iaf_pkg::item_t in_item;
  iaf_pkg::item_t stage_r [N+1];
  iaf_pkg::item_t cell_out [N];
  logic adv;
  logic out_held;

  // Advance the whole row when the output slot is empty or taken.
  assign adv = !stage_r[N].vld || !out_stall;
  assign in_stall = !adv;
  assign out_held = out_valid && out_stall;

  iaf_front u_front (.op(in_op), .a(in_left_operand), .b(in_right_operand),
                     .item(front_item));

  // Tag the front item with the input valid before it enters the row.
  always_comb begin
    in_item = front_item;
    in_item.vld = in_valid;
  end

  for (genvar g = 0; g < N; g++) begin : g_row
    iaf_cell #(.IDX(g)) u_cell (.i_item(stage_r[g]), .o_item(cell_out[g]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= N; k++) stage_r[k].vld <= 1'b0;
    end else if (adv) begin
      stage_r[0] <= in_item;
      for (int k = 0; k < N; k++) stage_r[k+1] <= cell_out[k];
    end
  end

  always_comb begin
    out_valid = stage_r[N].vld;
    out_folded = stage_r[N].ok;
    if (!stage_r[N].ok) out_result_value = '0;
    else if (stage_r[N].done) out_result_value = stage_r[N].q;
    else if (stage_r[N].op == iaf_pkg::OP_MUL) out_result_value = stage_r[N].mac;
    else if (stage_r[N].op == iaf_pkg::OP_REMU) out_result_value = stage_r[N].rem[N-1:0];
    else out_result_value = stage_r[N].q;
  end

  `ASSERT_CLK(a_stall_hold, clk, rst_n, out_held |=> out_valid && $stable(out_result_value),
              "result changed under stall")
  `ASSERT_CLK(a_in_stall, clk, rst_n, in_stall |-> out_held, "input stalled without output stall")
  `ASSERT_CLK(a_fold_zero, clk, rst_n, (out_valid && !out_folded) |-> out_result_value == '0,
              "unfolded result not zero")
endmodule
`default_nettype wire

// ===== rtl/core/iaf_front.sv =====
// Front cell: add, sub and logic ops, shifts, compares and item setup for the row.
`default_nettype none
module iaf_front (
  input  wire logic [iaf_pkg::OpW-1:0]   op,
  input  wire logic [iaf_pkg::DataW-1:0] a,
  input  wire logic [iaf_pkg::DataW-1:0] b,
  output iaf_pkg::item_t                  item
);
  localparam int unsigned W = iaf_pkg::DataW;
  logic big;
  logic [W-1:0] sh, sra;
  logic [$clog2(W)-1:0] amt;
  always_comb begin
    amt  = b[$clog2(W)-1:0];
    big  = |b[W-1:$clog2(W)];
    sra  = W'($signed(a) >>> amt);
    item = '0;
    item.vld = 1'b1;
    item.op = op;
    item.a = a;
    item.b = b;
    item.ok = 1'b1;
    item.done = 1'b1;
    sh = '0;
    unique case (op)
      iaf_pkg::OP_ADD:  item.q = a + b;
      iaf_pkg::OP_SUB:  item.q = a - b;
      iaf_pkg::OP_AND:  item.q = a & b;
      iaf_pkg::OP_OR:   item.q = a | b;
      iaf_pkg::OP_XOR:  item.q = a ^ b;
      iaf_pkg::OP_SHL:  item.q = big ? '0 : (a << amt);
      iaf_pkg::OP_SHRU: item.q = big ? '0 : (a >> amt);
      iaf_pkg::OP_SHRS: item.q = big ? {W{a[W-1]}} : sra;
      iaf_pkg::OP_EQ:   item.q = W'(a == b);
      iaf_pkg::OP_NE:   item.q = W'(a != b);
      iaf_pkg::OP_LTU:  item.q = W'(a < b);
      iaf_pkg::OP_LTS:  item.q = W'($signed(a) < $signed(b));
      iaf_pkg::OP_MUL, iaf_pkg::OP_DIVU, iaf_pkg::OP_REMU: begin
        item.done = 1'b0;
        item.ok = (op == iaf_pkg::OP_MUL) || (b != '0);
      end
      default: begin
        item.ok = 1'b0;
      end
    endcase
    item.mac = sh;
  end
endmodule
`default_nettype wire

// ===== rtl/core/iaf_cell.sv =====
// Row cell: one restoring-divide bit and, in the first four cells, one 16-bit multiply slice.
`default_nettype none
module iaf_cell #(
  parameter int unsigned IDX = 0
) (
  input  wire iaf_pkg::item_t i_item,
  output iaf_pkg::item_t      o_item
);
  localparam int unsigned W = iaf_pkg::DataW;
  localparam int unsigned DBIT = W - 1 - IDX;
  localparam int unsigned SLICE = 16;
  localparam int unsigned NSLICE = W / SLICE;
  logic [W:0] trial, sft;
  logic [W-1:0] part;
  always_comb begin
    o_item = i_item;
    sft = {i_item.rem[W-1:0], i_item.a[DBIT]};
    trial = sft - {1'b0, i_item.b};
    part = '0;
    if (!i_item.done) begin
      if (i_item.op == iaf_pkg::OP_MUL) begin
        if (IDX < NSLICE) begin
          part = W'(i_item.a * {48'd0, i_item.b[(IDX%NSLICE)*SLICE +: SLICE]})
                 << ((IDX % NSLICE) * SLICE);
          o_item.mac = i_item.mac + part;
        end
      end else begin
        o_item.rem = trial[W] ? sft : trial;
        o_item.q[DBIT] = ~trial[W];
      end
    end
  end
endmodule
`default_nettype wire
